// ----- rtl/tas_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the tensor axis sum block.
// No dependencies; imported by tas_pos_track and tensor_axis_sum_core.
package tas_pkg;

  // Parameter defaults
  localparam int MAX_DIM_SIZE_DEF = 16;
  localparam int SUM_DEPTH_DEF    = 4096;
  localparam int DATA_WIDTH_DEF   = 32;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 5;

  localparam logic [CFG_IDX_W-1:0] REG_NUM_DIMS  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_DIM0 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_DIM1 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_DIM2 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_DIM3 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_AXIS_MODE = 3'd5;

  // Axis mode codes
  localparam logic [2:0] MODE_AXIS_LAST = 3'd3;
  localparam logic [2:0] MODE_AUTO      = 3'd4;

  localparam logic [2:0] NUM_DIMS_MAX   = 3'd4;
  localparam logic [2:0] NUM_DIMS_RST   = 3'd1;
  localparam logic [4:0] SIZE_RST       = 5'd1;

  // Result queue between the accumulate stage and the output port
  localparam int            OUT_Q_DEPTH = 3;
  localparam logic [1:0]    OUT_Q_LAST  = 2'd2;

  typedef enum logic [1:0] {
    KIND_PASS,
    KIND_BAD_AXIS,
    KIND_SUM_ALL,
    KIND_ALONG_AXIS
  } kind_t;

  // Position information for the item being accepted
  typedef struct packed {
    kind_t kind;
    logic  first;    // first element along the axis for its slot
    logic  closing;  // last element along the axis for its slot
    logic  is_last;  // closes the tensor
  } pos_info_t;

endpackage

// ----- rtl/tensor_axis_sum_core.sv -----
`timescale 1ns / 1ps
// Top level of the tensor axis sum block: partial-sum memory, accumulate stage, result queue.
// Depends on tas_pkg and tas_pos_track.
//
//  channel | ports                                        | direction
//  --------+----------------------------------------------+----------
//  input   | in_valid, in_stall, in_element               | in
//  result  | out_valid, out_stall, out_total, out_last_of_tensor, out_bad_axis | out
//  config  | cfg_we, cfg_index, cfg_data                  | in
//
// One item per cycle sustained while in_stall is low. An item is read from the partial-sum
// memory at acceptance, accumulated in the next cycle and, at the edge that ends it, written
// back and pushed to the result queue, so out_valid rises then; a write-back to the slot
// being read is forwarded.
// Reset is synchronous; the partial-sum memory needs no clearing, so no start-up pass.
// A three-entry result queue absorbs output stalls; in_stall rises once it could overflow.
// Any register write restarts the tensor.
module tensor_axis_sum_core
  import tas_pkg::*;
#(
  parameter int MAX_DIM_SIZE = MAX_DIM_SIZE_DEF,
  parameter int SUM_DEPTH    = SUM_DEPTH_DEF,
  parameter int DATA_WIDTH   = DATA_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [DATA_WIDTH-1:0] in_element,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [DATA_WIDTH-1:0] out_total,
  output logic                         out_last_of_tensor,
  output logic                         out_bad_axis,
  input  logic                         cfg_we,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_data
);

  localparam int SW = $clog2(SUM_DEPTH);

  logic                  accept;
  logic                  restart;
  pos_info_t             trk_info;
  logic [SW-1:0]         trk_slot;

  logic [DATA_WIDTH-1:0] mem [SUM_DEPTH];
  logic [DATA_WIDTH-1:0] mem_q_r;
  logic                  fwd_hit_r;
  logic [DATA_WIDTH-1:0] fwd_data_r;

  logic                  s1_v_r;
  logic [DATA_WIDTH-1:0] s1_e_r;
  pos_info_t             s1_info_r;
  logic [SW-1:0]         s1_slot_r;
  logic [DATA_WIDTH-1:0] s1_operand;
  logic [DATA_WIDTH-1:0] s1_sum;
  logic                  s1_we;

  logic [DATA_WIDTH-1:0] gt_r;
  logic [DATA_WIDTH-1:0] gt_sum;

  logic                  emit;
  logic [DATA_WIDTH-1:0] res_total;
  logic                  res_last;
  logic                  res_bad;

  logic [DATA_WIDTH-1:0] q_total_r [OUT_Q_DEPTH];
  logic                  q_last_r  [OUT_Q_DEPTH];
  logic                  q_bad_r   [OUT_Q_DEPTH];
  logic [1:0]            q_head_r;
  logic [1:0]            q_tail_r;
  logic [1:0]            q_cnt_r;
  logic [1:0]            q_cnt_nxt;
  logic                  pop;
  logic [2:0]            occupancy;

  assign restart   = cfg_we && (cfg_index <= REG_AXIS_MODE);
  assign occupancy = {1'b0, q_cnt_r} + {2'b00, s1_v_r};
  assign in_stall  = (occupancy >= 3'(OUT_Q_DEPTH));
  assign accept    = in_valid && !in_stall;

  tas_pos_track #(
    .MAX_DIM_SIZE (MAX_DIM_SIZE),
    .SUM_DEPTH    (SUM_DEPTH)
  ) u_pos_track (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .adv       (accept),
    .info      (trk_info),
    .slot      (trk_slot)
  );

  // Accumulate stage
  assign s1_operand = fwd_hit_r ? fwd_data_r : mem_q_r;
  assign s1_sum     = (s1_info_r.first ? '0 : s1_operand) + s1_e_r;
  assign s1_we      = s1_v_r && (s1_info_r.kind == KIND_ALONG_AXIS) && !s1_info_r.closing;
  assign gt_sum     = gt_r + s1_e_r;

  always_comb begin
    emit      = 1'b0;
    res_total = s1_e_r;
    res_last  = s1_info_r.is_last;
    res_bad   = 1'b0;
    case (s1_info_r.kind)
      KIND_PASS: begin
        emit = s1_v_r;
      end
      KIND_BAD_AXIS: begin
        emit      = s1_v_r && s1_info_r.is_last;
        res_total = '0;
        res_last  = 1'b1;
        res_bad   = 1'b1;
      end
      KIND_SUM_ALL: begin
        emit      = s1_v_r && s1_info_r.is_last;
        res_total = gt_sum;
        res_last  = 1'b1;
      end
      KIND_ALONG_AXIS: begin
        emit      = s1_v_r && s1_info_r.closing;
        res_total = s1_sum;
      end
      default: emit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (s1_we) begin
      mem[s1_slot_r] <= s1_sum;
    end
    mem_q_r <= mem[trk_slot];
  end

  // Hold the write-back that lands on the slot read at the same edge
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_hit_r <= 1'b0;
    end else begin
      fwd_hit_r <= s1_we && (s1_slot_r == trk_slot);
    end
  end

  always_ff @(posedge clk) begin
    fwd_data_r <= s1_sum;
    if (accept) begin
      s1_e_r    <= in_element;
      s1_info_r <= trk_info;
      s1_slot_r <= trk_slot;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      gt_r <= '0;
    end else if (s1_v_r && (s1_info_r.kind == KIND_SUM_ALL)) begin
      gt_r <= s1_info_r.is_last ? '0 : gt_sum;
    end
  end

  // Result queue
  assign out_valid          = (q_cnt_r != 2'd0);
  assign pop                = out_valid && !out_stall;
  assign out_total          = q_total_r[q_head_r];
  assign out_last_of_tensor = q_last_r[q_head_r];
  assign out_bad_axis       = q_bad_r[q_head_r];

  always_comb begin
    q_cnt_nxt = q_cnt_r;
    if (emit && !pop) begin
      q_cnt_nxt = q_cnt_r + 2'd1;
    end else if (!emit && pop) begin
      q_cnt_nxt = q_cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      q_total_r[q_tail_r] <= res_total;
      q_last_r[q_tail_r]  <= res_last;
      q_bad_r[q_tail_r]   <= res_bad;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_head_r <= '0;
      q_tail_r <= '0;
      q_cnt_r  <= '0;
    end else begin
      q_cnt_r <= q_cnt_nxt;
      if (emit) begin
        q_tail_r <= (q_tail_r == OUT_Q_LAST) ? 2'd0 : q_tail_r + 2'd1;
      end
      if (pop) begin
        q_head_r <= (q_head_r == OUT_Q_LAST) ? 2'd0 : q_head_r + 2'd1;
      end
    end
  end

  // Checks
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_cnt_r <= 2'(OUT_Q_DEPTH))
    else $error("result queue overflow");

  a_bad_axis_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_bad_axis |-> (out_total == '0) && out_last_of_tensor)
    else $error("bad-axis result with nonzero total or not last");

  a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
    restart |=> (gt_r == '0))
    else $error("grand total not cleared on register write");

  a_full_push: assert property (@(posedge clk) disable iff (!rst_n)
    (q_cnt_r == 2'(OUT_Q_DEPTH)) && !pop |-> !emit)
    else $error("push into full result queue");

endmodule

// ----- rtl/tas_pos_track.sv -----
`timescale 1ns / 1ps
// Configuration registers, index counters and partial-sum slot counter.
// Depends on tas_pkg.
module tas_pos_track
  import tas_pkg::*;
#(
  parameter int MAX_DIM_SIZE = MAX_DIM_SIZE_DEF,
  parameter int SUM_DEPTH    = SUM_DEPTH_DEF,
  localparam int CW          = $clog2(MAX_DIM_SIZE),
  localparam int SW          = $clog2(SUM_DEPTH)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  adv,
  output pos_info_t             info,
  output logic [SW-1:0]         slot
);

  logic [2:0]    num_dims_r;
  logic [4:0]    size_r [4];
  logic [2:0]    mode_r;
  logic [CW-1:0] cnt_r [4];
  logic [CW-1:0] cnt_nxt [4];
  logic [SW-1:0] slot_r;
  logic [SW-1:0] slot_nxt;

  logic [2:0]    nd;
  logic [CW-1:0] szm1 [4];
  logic [1:0]    axis;
  logic          inner_wrap;
  logic          carry;
  logic          restart;
  logic          found;

  assign restart = cfg_we && (cfg_index <= REG_AXIS_MODE);

  always_comb begin
    nd = (num_dims_r > NUM_DIMS_MAX) ? NUM_DIMS_MAX : num_dims_r;
    for (int i = 0; i < 4; i++) begin
      if (size_r[i] == 5'd0) begin
        szm1[i] = '0;
      end else if (int'(size_r[i]) > MAX_DIM_SIZE) begin
        szm1[i] = CW'(MAX_DIM_SIZE - 1);
      end else begin
        szm1[i] = CW'(size_r[i] - 5'd1);
      end
    end
  end

  // Decode the summing axis and the kind of work for this tensor
  always_comb begin
    info.kind = KIND_PASS;
    axis      = '0;
    found     = 1'b0;
    if (nd == 3'd0) begin
      info.kind = KIND_PASS;
    end else begin
      case (mode_r) inside
        [3'd0:MODE_AXIS_LAST]: begin
          if (mode_r >= nd) begin
            info.kind = KIND_BAD_AXIS;
          end else begin
            info.kind = KIND_ALONG_AXIS;
            axis      = mode_r[1:0];
          end
        end
        MODE_AUTO: begin
          for (int i = 0; i < 4; i++) begin
            if (!found && (3'(i) < nd) && (szm1[i] != '0)) begin
              found = 1'b1;
              axis  = 2'(i);
            end
          end
          info.kind = found ? KIND_ALONG_AXIS : KIND_PASS;
        end
        default: info.kind = KIND_SUM_ALL;
      endcase
    end

    info.is_last = 1'b1;
    inner_wrap   = 1'b1;
    for (int i = 0; i < 4; i++) begin
      if ((3'(i) < nd) && (cnt_r[i] != szm1[i])) begin
        info.is_last = 1'b0;
        if (2'(i) > axis) begin
          inner_wrap = 1'b0;
        end
      end
    end
    info.first   = (cnt_r[axis] == '0);
    info.closing = (cnt_r[axis] == szm1[axis]);
  end

  // Row-major advance: innermost used dimension counts fastest
  always_comb begin
    carry = 1'b1;
    for (int d = 3; d >= 0; d--) begin
      cnt_nxt[d] = cnt_r[d];
      if ((3'(d) < nd) && carry) begin
        if (cnt_r[d] == szm1[d]) begin
          cnt_nxt[d] = '0;
        end else begin
          cnt_nxt[d] = cnt_r[d] + 1'b1;
          carry      = 1'b0;
        end
      end
    end
  end

  // Slot tracks the linear index after the axis, modulo the store depth
  always_comb begin
    if (inner_wrap || (slot_r == SW'(SUM_DEPTH - 1))) begin
      slot_nxt = '0;
    end else begin
      slot_nxt = slot_r + 1'b1;
    end
  end

  assign slot = slot_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_dims_r <= NUM_DIMS_RST;
      mode_r     <= MODE_AUTO;
      for (int i = 0; i < 4; i++) begin
        size_r[i] <= SIZE_RST;
      end
    end else if (cfg_we) begin
      case (cfg_index)
        REG_NUM_DIMS:  num_dims_r <= cfg_data[2:0];
        REG_SIZE_DIM0: size_r[0]  <= cfg_data;
        REG_SIZE_DIM1: size_r[1]  <= cfg_data;
        REG_SIZE_DIM2: size_r[2]  <= cfg_data;
        REG_SIZE_DIM3: size_r[3]  <= cfg_data;
        REG_AXIS_MODE: mode_r     <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      slot_r <= '0;
      for (int i = 0; i < 4; i++) begin
        cnt_r[i] <= '0;
      end
    end else if (adv) begin
      slot_r <= slot_nxt;
      for (int i = 0; i < 4; i++) begin
        cnt_r[i] <= cnt_nxt[i];
      end
    end
  end

endmodule
